[rtl/battery_level_gauge_top_macros.svh]
// Assertion macros for the checker file of the battery gauge.
`ifndef BATTERY_LEVEL_GAUGE_TOP_MACROS_SVH
`define BATTERY_LEVEL_GAUGE_TOP_MACROS_SVH

// Checked on every clock edge outside of reset.
`define BLG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define BLG_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[rtl/blg_pkg.sv]
package blg_pkg;

  // Field widths.
  localparam int unsigned ADC_BITS   = 10;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned MV_W       = 13;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned TICK_W     = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Burst limits.
  localparam logic [CNT_W-1:0] MAX_SAMPLES = 7'd64;

  // Input command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_EMPTY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_FULL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_MS   = 3'd4;

  // Configuration reset values.
  localparam logic [CNT_W-1:0]    RST_SAMPLE_COUNT = 7'd10;
  localparam logic [LEVEL_W-1:0]  RST_LOW_LEVEL    = 7'd20;
  localparam logic [ADC_BITS-1:0] RST_ADC_EMPTY    = 10'd440;
  localparam logic [ADC_BITS-1:0] RST_ADC_FULL     = 10'd556;
  localparam logic [HOLD_W-1:0]   RST_HOLDOFF_MS   = 16'd30000;

  // Scaling constants.
  localparam logic [TICK_W-1:0]  TICK_MAX   = 17'h1FFFF;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;

  // Divider geometry.
  localparam int unsigned DIV_DVD_W = 29;
  localparam int unsigned DIV_DSR_W = 16;
  localparam int unsigned DIV_Q_W   = 13;
  localparam int unsigned DIV_K_W   = 5;

  // Quotient bits needed by each division.
  localparam logic [DIV_K_W-1:0] DIV_Q_MEAN = 5'd10;
  localparam logic [DIV_K_W-1:0] DIV_Q_MV   = 5'd13;
  localparam logic [DIV_K_W-1:0] DIV_Q_LVL  = 5'd7;

  // Job queue depth.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef struct packed {
    logic [CNT_W-1:0]    sample_count;
    logic [LEVEL_W-1:0]  low_level;
    logic [ADC_BITS-1:0] adc_empty;
    logic [ADC_BITS-1:0] adc_full;
    logic [HOLD_W-1:0]   holdoff_ms;
  } cfg_t;

  // One queued job: either a tick or a finished burst.
  typedef struct packed {
    logic                is_tick;
    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    count;
    logic [ADC_BITS-1:0] last;
  } job_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DSR_W-1:0] divisor;
    logic [DIV_K_W-1:0]   qbits;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/blg_if.sv]
interface blg_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [9:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink (input valid, input cmd, input sample, output ready);
endinterface

interface blg_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  battery_level;
  logic [12:0] voltage_mv;
  logic [9:0]  mean_raw;
  logic [9:0]  last_raw;
  logic        low_battery_alert;

  modport source (
    output valid, output battery_level, output voltage_mv, output mean_raw,
    output last_raw, output low_battery_alert, input ready
  );
  modport sink (
    input valid, input battery_level, input voltage_mv, input mean_raw,
    input last_raw, input low_battery_alert, output ready
  );
endinterface

[rtl/blg_front.sv]
module blg_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  blg_in_if.sink                        in_ch,
  input  logic [blg_pkg::CNT_W-1:0]     sample_count_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output blg_pkg::job_t                 push_data_o
);

  logic [blg_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [blg_pkg::CNT_W-1:0] taken_q, taken_d;
  logic [blg_pkg::CNT_W-1:0] burst_len;
  logic [blg_pkg::SUM_W-1:0] sum_next;
  logic [blg_pkg::CNT_W-1:0] taken_next;
  logic                      accept;
  logic                      burst_end;

  // A zero count acts as one, a count above the limit acts as the limit.
  always_comb begin
    if (sample_count_i == '0) begin
      burst_len = 7'd1;
    end else if (sample_count_i > blg_pkg::MAX_SAMPLES) begin
      burst_len = blg_pkg::MAX_SAMPLES;
    end else begin
      burst_len = sample_count_i;
    end
  end

  assign in_ch.ready = push_ready_i;
  assign accept      = in_ch.valid && push_ready_i;

  assign sum_next   = sum_q + {{(blg_pkg::SUM_W - blg_pkg::ADC_BITS){1'b0}}, in_ch.sample};
  assign taken_next = taken_q + 7'd1;
  assign burst_end  = taken_next >= burst_len;

  // Ticks always go to the queue; samples only when they close a burst.
  assign push_valid_o = accept && ((in_ch.cmd == blg_pkg::CMD_TICK) || burst_end);
  always_comb begin
    push_data_o.is_tick = (in_ch.cmd == blg_pkg::CMD_TICK);
    push_data_o.sum     = sum_next;
    push_data_o.count   = taken_next;
    push_data_o.last    = in_ch.sample;
  end

  // Running burst accumulation.
  always_comb begin
    sum_d   = sum_q;
    taken_d = taken_q;
    if (accept && (in_ch.cmd == blg_pkg::CMD_SAMPLE)) begin
      if (burst_end) begin
        sum_d   = '0;
        taken_d = '0;
      end else begin
        sum_d   = sum_next;
        taken_d = taken_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      taken_q <= '0;
    end else begin
      sum_q   <= sum_d;
      taken_q <= taken_d;
    end
  end

endmodule

[rtl/blg_fifo.sv]
module blg_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  blg_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output blg_pkg::job_t pop_data_o
);

  blg_pkg::job_t                      mem_q [blg_pkg::FIFO_DEPTH];
  logic [blg_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [blg_pkg::FIFO_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [blg_pkg::FIFO_CNT_W-1:0]     cnt_q, cnt_d;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready_o = cnt_q != blg_pkg::FIFO_CNT_W'(blg_pkg::FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/blg_div.sv]
module blg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  blg_pkg::div_req_t req_i,
  output blg_pkg::div_rsp_t rsp_o
);

  logic [blg_pkg::DIV_DSR_W-1:0] rem_q, rem_d;
  logic [blg_pkg::DIV_DVD_W-1:0] dvd_q, dvd_d;
  logic [blg_pkg::DIV_DSR_W-1:0] dsr_q, dsr_d;
  logic [blg_pkg::DIV_Q_W-1:0]   quot_q, quot_d;
  logic [blg_pkg::DIV_K_W-1:0]   k_q, k_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [blg_pkg::DIV_DSR_W:0]   trial;
  logic                          qbit;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign trial = {rem_q, dvd_q[k_q]};
  assign qbit  = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    k_d    = k_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // The caller guarantees the upper part stays below the divisor.
      rem_d  = blg_pkg::DIV_DSR_W'(req_i.dividend >> req_i.qbits);
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      quot_d = '0;
      k_d    = req_i.qbits - 1'b1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = qbit ? blg_pkg::DIV_DSR_W'(trial - {1'b0, dsr_q})
                    : blg_pkg::DIV_DSR_W'(trial);
      quot_d = {quot_q[blg_pkg::DIV_Q_W-2:0], qbit};
      k_d    = k_q - 1'b1;
      if (k_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[rtl/blg_back.sv]
module blg_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  blg_pkg::cfg_t cfg_i,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  blg_pkg::job_t pop_data_i,
  blg_out_if.source     out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MEAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_MVST = 3'd3;
  localparam logic [2:0] S_MV   = 3'd4;
  localparam logic [2:0] S_LVST = 3'd5;
  localparam logic [2:0] S_LVL  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]                       state_q, state_d;
  logic [blg_pkg::TICK_W-1:0]       tick_q, tick_d;
  logic [blg_pkg::SUM_W-1:0]        sum_q, sum_d;
  logic [blg_pkg::CNT_W-1:0]        n_q, n_d;
  logic [blg_pkg::ADC_BITS-1:0]     last_q, last_d;
  logic [blg_pkg::ADC_BITS-1:0]     mean_q, mean_d;
  logic [blg_pkg::MV_W-1:0]         mv_q, mv_d;
  logic [blg_pkg::LEVEL_W-1:0]      lvl_q, lvl_d;
  logic [blg_pkg::DIV_DVD_W-1:0]    prod_q, prod_d;
  logic [blg_pkg::DIV_DSR_W-1:0]    den_q, den_d;
  logic [16:0]                      lnum_q, lnum_d;
  logic [blg_pkg::ADC_BITS-1:0]     lden_q, lden_d;
  logic                             out_valid_q, out_valid_d;
  logic [blg_pkg::LEVEL_W-1:0]      o_level_q, o_level_d;
  logic [blg_pkg::MV_W-1:0]         o_mv_q, o_mv_d;
  logic [blg_pkg::ADC_BITS-1:0]     o_mean_q, o_mean_d;
  logic [blg_pkg::ADC_BITS-1:0]     o_last_q, o_last_d;
  logic                             o_alert_q, o_alert_d;
  logic                             alert;
  blg_pkg::div_req_t                div_req;
  blg_pkg::div_rsp_t                div_rsp;

  blg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pop_ready_o = (state_q == S_IDLE);

  assign alert = (lvl_q < cfg_i.low_level) && (tick_q > {1'b0, cfg_i.holdoff_ms});

  // Job sequencer: counts ticks, and runs a burst's divisions one after another through the shared divider.
  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    sum_d       = sum_q;
    n_d         = n_q;
    last_d      = last_q;
    mean_d      = mean_q;
    mv_d        = mv_q;
    lvl_d       = lvl_q;
    prod_d      = prod_q;
    den_d       = den_q;
    lnum_d      = lnum_q;
    lden_d      = lden_q;
    out_valid_d = out_valid_q;
    o_level_d   = o_level_q;
    o_mv_d      = o_mv_q;
    o_mean_d    = o_mean_q;
    o_last_d    = o_last_q;
    o_alert_d   = o_alert_q;
    div_req     = '0;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          if (pop_data_i.is_tick) begin
            if (tick_q != blg_pkg::TICK_MAX) begin
              tick_d = tick_q + 1'b1;
            end
          end else begin
            sum_d            = pop_data_i.sum;
            n_d              = pop_data_i.count;
            last_d           = pop_data_i.last;
            div_req.start    = 1'b1;
            div_req.dividend = {{(blg_pkg::DIV_DVD_W - blg_pkg::SUM_W){1'b0}},
                                pop_data_i.sum};
            div_req.divisor  = {{(blg_pkg::DIV_DSR_W - blg_pkg::CNT_W){1'b0}},
                                pop_data_i.count};
            div_req.qbits    = blg_pkg::DIV_Q_MEAN;
            state_d          = S_MEAN;
          end
        end
      end
      S_MEAN: begin
        if (div_rsp.done) begin
          mean_d  = div_rsp.quot[blg_pkg::ADC_BITS-1:0];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // Scale products for the voltage and the level, each registered.
        prod_d = {{(blg_pkg::DIV_DVD_W - blg_pkg::SUM_W){1'b0}}, sum_q} * 29'd7494;
        den_d  = {{(blg_pkg::DIV_DSR_W - blg_pkg::CNT_W){1'b0}}, n_q} * 16'd1000;
        lnum_d = {7'd0, mean_q - cfg_i.adc_empty} * 17'd100;
        lden_d = cfg_i.adc_full - cfg_i.adc_empty;
        state_d = S_MVST;
      end
      S_MVST: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = den_q;
        div_req.qbits    = blg_pkg::DIV_Q_MV;
        state_d          = S_MV;
      end
      S_MV: begin
        if (div_rsp.done) begin
          mv_d    = div_rsp.quot;
          state_d = S_LVST;
        end
      end
      S_LVST: begin
        // Settle the easy level cases without dividing.
        if (mean_q <= cfg_i.adc_empty) begin
          lvl_d   = '0;
          state_d = S_OUT;
        end else if (cfg_i.adc_full <= cfg_i.adc_empty) begin
          lvl_d   = blg_pkg::LEVEL_FULL;
          state_d = S_OUT;
        end else if (lnum_q[16:7] >= lden_q) begin
          lvl_d   = blg_pkg::LEVEL_FULL;
          state_d = S_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {{(blg_pkg::DIV_DVD_W - 17){1'b0}}, lnum_q};
          div_req.divisor  = {{(blg_pkg::DIV_DSR_W - blg_pkg::ADC_BITS){1'b0}}, lden_q};
          div_req.qbits    = blg_pkg::DIV_Q_LVL;
          state_d          = S_LVL;
        end
      end
      S_LVL: begin
        if (div_rsp.done) begin
          if (div_rsp.quot[blg_pkg::LEVEL_W-1:0] > blg_pkg::LEVEL_FULL) begin
            lvl_d = blg_pkg::LEVEL_FULL;
          end else begin
            lvl_d = div_rsp.quot[blg_pkg::LEVEL_W-1:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // Load the output register once the previous result has left.
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          o_level_d   = lvl_q;
          o_mv_d      = mv_q;
          o_mean_d    = mean_q;
          o_last_d    = last_q;
          o_alert_d   = alert;
          if (alert) begin
            tick_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    n_q       <= n_d;
    last_q    <= last_d;
    mean_q    <= mean_d;
    mv_q      <= mv_d;
    lvl_q     <= lvl_d;
    prod_q    <= prod_d;
    den_q     <= den_d;
    lnum_q    <= lnum_d;
    lden_q    <= lden_d;
    o_level_q <= o_level_d;
    o_mv_q    <= o_mv_d;
    o_mean_q  <= o_mean_d;
    o_last_q  <= o_last_d;
    o_alert_q <= o_alert_d;
  end

  assign out_ch.valid             = out_valid_q;
  assign out_ch.battery_level     = o_level_q;
  assign out_ch.voltage_mv        = o_mv_q;
  assign out_ch.mean_raw          = o_mean_q;
  assign out_ch.last_raw          = o_last_q;
  assign out_ch.low_battery_alert = o_alert_q;

endmodule

[rtl/battery_level_gauge_top.sv]
// Ticks and samples that do not close a burst are taken at one per cycle while
// the job queue has room. A closing sample's result comes from passes through
// one shared radix-2 divider (mean, voltage, then level unless no division
// is needed); the back end pops no new job until that result is registered.
// Reset clears the burst sum, the tick counter and the result handshake,
// and loads the configuration registers with their default values.
module battery_level_gauge_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  blg_in_if.sink                             in_ch,
  blg_out_if.source                          out_ch,
  input  logic                               cfg_we_i,
  input  logic [blg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [blg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  blg_pkg::cfg_t cfg_q, cfg_d;
  logic          push_valid;
  logic          push_ready;
  blg_pkg::job_t push_data;
  logic          pop_valid;
  logic          pop_ready;
  blg_pkg::job_t pop_data;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        blg_pkg::CFG_SAMPLE_COUNT: cfg_d.sample_count = cfg_data_i[blg_pkg::CNT_W-1:0];
        blg_pkg::CFG_LOW_LEVEL:    cfg_d.low_level    = cfg_data_i[blg_pkg::LEVEL_W-1:0];
        blg_pkg::CFG_ADC_EMPTY:    cfg_d.adc_empty    = cfg_data_i[blg_pkg::ADC_BITS-1:0];
        blg_pkg::CFG_ADC_FULL:     cfg_d.adc_full     = cfg_data_i[blg_pkg::ADC_BITS-1:0];
        blg_pkg::CFG_HOLDOFF_MS:   cfg_d.holdoff_ms   = cfg_data_i[blg_pkg::HOLD_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_count <= blg_pkg::RST_SAMPLE_COUNT;
      cfg_q.low_level    <= blg_pkg::RST_LOW_LEVEL;
      cfg_q.adc_empty    <= blg_pkg::RST_ADC_EMPTY;
      cfg_q.adc_full     <= blg_pkg::RST_ADC_FULL;
      cfg_q.holdoff_ms   <= blg_pkg::RST_HOLDOFF_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  blg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_ch          (in_ch),
    .sample_count_i (cfg_q.sample_count),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  blg_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  blg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_ch      (out_ch)
  );

endmodule

[rtl/blg_checker.sv]
`include "battery_level_gauge_top_macros.svh"

module blg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [6:0]  battery_level_i,
  input logic [12:0] voltage_mv_i,
  input logic [9:0]  mean_raw_i
);

  // A stalled result keeps its level and voltage.
  `BLG_ASSERT_RST(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(battery_level_i) && $stable(voltage_mv_i), "stalled result changed")

  // The level never leaves the percent range.
  `BLG_ASSERT_RST(a_level_range, out_valid_i |-> battery_level_i <= 7'd100, "level above full scale")

  // The voltage scale factor is above seven, so the voltage tracks the mean.
  `BLG_ASSERT_RST(a_mv_vs_mean, out_valid_i |-> voltage_mv_i >= ({3'b000, mean_raw_i} * 13'd7), "voltage below scaled mean")

  // No result is offered while reset is applied.
  `BLG_ASSERT_ANY(a_reset_quiet, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind battery_level_gauge_top blg_checker u_blg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .battery_level_i (out_ch.battery_level),
  .voltage_mv_i    (out_ch.voltage_mv),
  .mean_raw_i      (out_ch.mean_raw)
);

[sim/testbench.sv]
module testbench;
  import blg_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 2_000_000;
  localparam int unsigned DRAIN_CYCLES     = 120;
  localparam int unsigned LONG_HOLD_CYCLES = 500;
  localparam int unsigned RANDOM_PHASES    = 12;
  localparam int unsigned ITEMS_PER_PHASE  = 146;
  localparam int unsigned MV_SCALE         = 7494;
  localparam int unsigned MV_DIV           = 1000;
  localparam int unsigned ADC_MAX          = 1023;
  localparam int unsigned HOLD_MAX         = 65535;
  localparam int unsigned LEVEL_REG_MAX    = 127;
  localparam int unsigned COUNT_REG_MAX    = 127;

  // First register index past the defined ones; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_HOLDOFF_MS + 3'd1;

  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum {SMP_UNIFORM, SMP_WINDOW, SMP_HIGH} sample_mode_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [MV_W-1:0]     mv;
    logic [ADC_BITS-1:0] mean;
    logic [ADC_BITS-1:0] last;
    logic                alert;
  } gauge_result_t;

  // Tracks the gauge state and the measurements it owes.
  class gauge_scoreboard;
    logic [CNT_W-1:0]    count_reg;
    logic [LEVEL_W-1:0]  low_reg;
    logic [ADC_BITS-1:0] empty_reg;
    logic [ADC_BITS-1:0] full_reg;
    logic [HOLD_W-1:0]   holdoff_reg;
    logic [SUM_W-1:0]    sum_acc;
    logic [CNT_W-1:0]    taken;
    logic [TICK_W-1:0]   ms_ticks;
    logic [ADC_BITS-1:0] latest;
    gauge_result_t       pending_results[$];
    int unsigned         errors;

    function new();
      count_reg   = RST_SAMPLE_COUNT;
      low_reg     = RST_LOW_LEVEL;
      empty_reg   = RST_ADC_EMPTY;
      full_reg    = RST_ADC_FULL;
      holdoff_reg = RST_HOLDOFF_MS;
      sum_acc     = '0;
      taken       = '0;
      ms_ticks    = '0;
      latest      = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SAMPLE_COUNT: count_reg   = data[CNT_W-1:0];
        CFG_LOW_LEVEL:    low_reg     = data[LEVEL_W-1:0];
        CFG_ADC_EMPTY:    empty_reg   = data[ADC_BITS-1:0];
        CFG_ADC_FULL:     full_reg    = data[ADC_BITS-1:0];
        CFG_HOLDOFF_MS:   holdoff_reg = data[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    // Percent level of a mean; an inverted calibration acts as a step.
    function int unsigned level_of(int unsigned mean);
      int unsigned lv;
      if (mean <= empty_reg) return 0;
      if (full_reg <= empty_reg) return LEVEL_FULL;
      lv = ((mean - empty_reg) * LEVEL_FULL) / (full_reg - empty_reg);
      return (lv > LEVEL_FULL) ? LEVEL_FULL : lv;
    endfunction

    // Applies one accepted input transfer and queues the measurement it closes.
    function void note_input(logic cmd, logic [ADC_BITS-1:0] s);
      int unsigned   n;
      int unsigned   burst_len;
      int unsigned   mean;
      int unsigned   level;
      int unsigned   mv;
      gauge_result_t r;
      if (cmd == CMD_TICK) begin
        if (ms_ticks != TICK_MAX) ms_ticks = ms_ticks + 1'b1;
        return;
      end
      latest  = s;
      sum_acc = sum_acc + s;
      taken   = taken + 1'b1;
      if (count_reg == 0) burst_len = 1;
      else if (count_reg > MAX_SAMPLES) burst_len = MAX_SAMPLES;
      else burst_len = count_reg;
      if (taken < burst_len) return;
      n       = taken;
      mean    = sum_acc / n;
      level   = level_of(mean);
      mv      = (sum_acc * MV_SCALE) / (n * MV_DIV);
      r.level = LEVEL_W'(level);
      r.mv    = MV_W'(mv);
      r.mean  = ADC_BITS'(mean);
      r.last  = latest;
      r.alert = (level < low_reg) && (ms_ticks > holdoff_reg);
      if (r.alert) ms_ticks = '0;
      pending_results.push_back(r);
      sum_acc = '0;
      taken   = '0;
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compares one output transfer with the oldest owed measurement.
    function void check_result(gauge_result_t got);
      gauge_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual level %0d mv %0d mean %0d",
                 $time, got.level, got.mv, got.mean);
        return;
      end
      want = pending_results.pop_front();
      if (got.level !== want.level) report("battery_level", want.level, got.level);
      if (got.mv !== want.mv) report("voltage_mv", want.mv, got.mv);
      if (got.mean !== want.mean) report("mean_raw", want.mean, got.mean);
      if (got.last !== want.last) report("last_raw", want.last, got.last);
      if (got.alert !== want.alert) report("low_battery_alert", want.alert, got.alert);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  blg_in_if  in_ch ();
  blg_out_if out_ch ();

  gauge_scoreboard gauge_sb = new();

  int unsigned burst_left   = 0;
  bit          hold_pending = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;

  battery_level_gauge_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Result sink: checks each output transfer and stalls in changing patterns.
  initial begin
    int unsigned   stretch_left;
    int unsigned   rx_phase;
    rx_mode_e      rx_mode;
    gauge_result_t got;
    out_ch.ready <= 1'b0;
    stretch_left = 0;
    rx_phase     = 0;
    rx_mode      = RX_ALWAYS;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.level = out_ch.battery_level;
        got.mv    = out_ch.voltage_mv;
        got.mean  = out_ch.mean_raw;
        got.last  = out_ch.last_raw;
        got.alert = out_ch.low_battery_alert;
        gauge_sb.check_result(got);
      end
      rx_phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_pending) begin
        // Long hold-off so that the block backs up and stalls its input.
        hold_pending = 1'b0;
        hold_left    = LONG_HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
          stretch_left = $urandom_range(16, 200);
        end
        stretch_left--;
        case (rx_mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= (rx_phase % 3 != 0);
        endcase
      end
    end
  end

  // Offers one input item and waits for its transfer; gaps come between bursts.
  task automatic send_item(input logic cmd, input logic [ADC_BITS-1:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(40, 150);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(0, 10);
      end
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= cmd;
    in_ch.sample <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    gauge_sb.note_input(cmd, s);
  endtask

  task automatic send_sample(input logic [ADC_BITS-1:0] s);
    send_item(CMD_SAMPLE, s);
  endtask

  // The sample field of a tick carries noise.
  task automatic send_tick();
    send_item(CMD_TICK, ADC_BITS'($urandom));
  endtask

  // Waits until every measurement has come out and the tick backlog is gone.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (gauge_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Bits above the register width carry noise that the block must drop.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                           input int unsigned width);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(($urandom << width) | value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    gauge_sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(input int unsigned count, input int unsigned low,
                                input int unsigned empty, input int unsigned full,
                                input int unsigned hold);
    write_cfg(CFG_IDX_W'(CFG_SPARE + $urandom_range(0, 2)), $urandom, 0);
    write_cfg(CFG_SAMPLE_COUNT, count, CNT_W);
    write_cfg(CFG_LOW_LEVEL, low, LEVEL_W);
    write_cfg(CFG_ADC_EMPTY, empty, ADC_BITS);
    write_cfg(CFG_ADC_FULL, full, ADC_BITS);
    write_cfg(CFG_HOLDOFF_MS, hold, HOLD_W);
    cfg_we_i <= 1'b0;
  endtask

  // Samples: some rails, the rest uniform, near the calibration span, or near full scale.
  function automatic logic [ADC_BITS-1:0] pick_sample(sample_mode_e mode, int unsigned lo,
                                                      int unsigned hi);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    case (mode)
      SMP_WINDOW: return ADC_BITS'($urandom_range(lo, hi));
      SMP_HIGH:   return ADC_BITS'(ADC_MAX - $urandom_range(0, 3));
      default:    return ADC_BITS'($urandom_range(0, ADC_MAX));
    endcase
  endfunction

  // Stimulus.
  initial begin
    int unsigned  burst_a[10];
    int unsigned  count;
    int unsigned  low;
    int unsigned  empty;
    int unsigned  full;
    int unsigned  hold;
    int unsigned  tick_pct;
    sample_mode_e smode;

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= '0;
    cfg_data_i   <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_SAMPLE;
    in_ch.sample <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default settings: a tick, then one full burst with both rails.
    burst_a = '{1023, 0, 682, 341, 1023, 1023, 1023, 1023, 1023, 1023};
    send_item(CMD_TICK, '1);
    foreach (burst_a[i]) send_sample(ADC_BITS'(burst_a[i]));
    drain();

    // Single-sample bursts, full span, no holdoff: alert on an empty reading.
    apply_settings(1, 100, 0, ADC_MAX, 0);
    send_tick();
    send_sample('0);
    send_sample('1);
    drain();

    // Zero count acts as one; inverted calibration acts as a step at empty.
    apply_settings(0, 50, 500, 400, 0);
    send_tick();
    send_sample(10'd600);
    send_sample(10'd500);
    send_sample(10'd499);
    drain();

    // Equal calibration points.
    apply_settings(1, 100, 300, 300, HOLD_MAX);
    send_sample(10'd301);
    send_sample(10'd300);
    drain();

    // Count lowered mid-burst: the next sample closes a burst of four.
    apply_settings(5, 0, 256, 512, HOLD_MAX);
    repeat (3) send_sample(10'd300);
    drain();
    apply_settings(2, 0, 256, 512, HOLD_MAX);
    send_sample(10'd700);
    drain();

    // Random phases, each with its own settings.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0:       count = 0;
        1:       count = MAX_SAMPLES;
        2:       count = $urandom_range(MAX_SAMPLES + 1, COUNT_REG_MAX);
        3, 4:    count = 1;
        default: count = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 5))
        0:       low = 0;
        1:       low = LEVEL_FULL;
        2:       low = LEVEL_REG_MAX;
        default: low = $urandom_range(1, 99);
      endcase
      case ($urandom_range(0, 5))
        0: begin
          empty = 0;
          full  = ADC_MAX;
        end
        1: begin
          empty = ADC_MAX - 1;
          full  = ADC_MAX;
        end
        2: begin
          full  = $urandom_range(0, 511);
          empty = $urandom_range(full, ADC_MAX);
        end
        default: begin
          empty = $urandom_range(0, 900);
          full  = $urandom_range(empty + 1, ADC_MAX);
        end
      endcase
      case ($urandom_range(0, 4))
        0:       hold = 0;
        1:       hold = HOLD_MAX;
        default: hold = $urandom_range(1, 80);
      endcase
      tick_pct = $urandom_range(10, 60);
      smode    = sample_mode_e'($urandom_range(0, 2));
      // One phase fills the largest burst with near full-scale samples.
      if (phase == 1) begin
        count    = MAX_SAMPLES;
        smode    = SMP_HIGH;
        tick_pct = 10;
      end
      // Back-pressure phases use one-sample bursts so results pile up.
      if (phase == 0 || phase == RANDOM_PHASES / 2) count = 1;
      apply_settings(count, low, empty, full, hold);
      if (phase == 0 || phase == RANDOM_PHASES / 2) hold_pending = 1'b1;
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 99) < tick_pct) send_tick();
        else send_sample(pick_sample(smode, empty, full));
      end
      drain();
    end

    if (gauge_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/blg_pkg.sv
rtl/blg_if.sv
rtl/blg_front.sv
rtl/blg_fifo.sv
rtl/blg_div.sv
rtl/blg_back.sv
rtl/battery_level_gauge_top.sv
rtl/blg_checker.sv
sim/testbench.sv
